/* rtl/swms_pkg.sv */
// ----------------------------------------------------------------------------
// swms_pkg: shared types and constants for the sliding window mode filter
// Holds the request/response word types and the configuration register map.
// ----------------------------------------------------------------------------
package swms_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 48;
   localparam int WSIZE_W  = 7;

   // register indexes
   localparam logic [0:0] REG_WINDOW_SIZE = 1'd0;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                restart;
   } req_word_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mode;
      logic [SUM_W-1:0]    mode_sum;
      logic                sum_saturated;
   } rsp_word_type;

   // word passed from the front end to the back end
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                restart;
      logic                emit;
      logic [WSIZE_W-1:0]  win;
   } job_type;

endpackage

/* rtl/swms_front.sv */
// ----------------------------------------------------------------------------
// swms_front: input stage
// Accepts sample words, tracks fill level, decides whether a result follows.
// ----------------------------------------------------------------------------
module swms_front
   import swms_pkg::*;
#(
   parameter int MAX_WINDOW = 64,
   parameter int FW = $clog2(MAX_WINDOW+1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_word,
   input  logic [WSIZE_W-1:0] win_size,
   output logic               job_valid,
   input  logic               job_stall,
   output job_type            job
);

   logic [FW-1:0] fill_ff, fill_in, fill_base;
   logic [FW-1:0] eff;
   logic          acc;

   assign req_stall = job_stall;
   assign acc       = req_valid && !req_stall;
   assign job_valid = req_valid;

   // clamp window size into 1..MAX_WINDOW
   always_comb begin
      if (win_size == '0) eff = FW'(1);
      else if (32'(win_size) > MAX_WINDOW) eff = FW'(MAX_WINDOW);
      else eff = FW'(win_size);
   end

   always_comb begin
      fill_base = req_word.restart ? '0 : fill_ff;
      fill_in   = (32'(fill_base) < MAX_WINDOW) ? fill_base + FW'(1) : fill_base;
   end

   always_comb begin
      job.sample  = req_word.sample;
      job.restart = req_word.restart;
      job.emit    = fill_in >= eff;
      job.win     = WSIZE_W'(eff);
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else if (acc) fill_ff <= fill_in;
   end

endmodule

/* rtl/swms_queue.sv */
// ----------------------------------------------------------------------------
// swms_queue: two-entry job queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module swms_queue
   import swms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_stall,
   output job_type out_job
);

   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = cnt_ff == 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_job   = mem_ff[rp_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

/* rtl/swms_back.sv */
// ----------------------------------------------------------------------------
// swms_back: window and tally engine
// Keeps the window as a row of cells; each cell counts matches of its own
// sample among the newest window_size samples, then a combinational compare
// over the registered counts picks the mode, registered with the updated sum.
// ----------------------------------------------------------------------------
module swms_back
   import swms_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   output logic         job_stall,
   input  job_type      job,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int CW = $clog2(MAX_WINDOW+1);
   localparam int LV = $clog2(MAX_WINDOW);
   localparam int NP = 1 << LV;
   localparam logic [1:0] ST_IDLE = 2'd0, ST_TALLY = 2'd1, ST_PICK = 2'd2;

   // window as a shift line: cell 0 is the newest sample
   logic [SAMPLE_W-1:0]    win_ff [MAX_WINDOW];
   logic [CW-1:0]          cnt_ff [MAX_WINDOW];
   logic [1:0]             st_ff;
   logic [CW-1:0]          w_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   sat_ff, sat_in;
   logic                   ov_ff;
   rsp_word_type           out_ff;
   logic                   take;
   logic [SAMPLE_W-1:0]    best_v;
   logic [SAMPLE_W-1:0]    tv [NP];
   logic [CW-1:0]          tc [NP];
   logic [SUM_W:0]         add;

   assign job_stall = st_ff != ST_IDLE || (ov_ff && rsp_stall);
   assign take      = job_valid && !job_stall;
   assign rsp_valid = ov_ff;
   assign rsp_word  = out_ff;

   // per-cell match count over the window (independent per cell)
   always_ff @(posedge clock) begin
      if (st_ff == ST_TALLY) begin
         for (int c = 0; c < MAX_WINDOW; c++) begin
            logic [MAX_WINDOW-1:0] hit;
            for (int k = 0; k < MAX_WINDOW; k++)
               hit[k] = (k < 32'(w_ff)) && (win_ff[k] == win_ff[c]);
            cnt_ff[c] <= (c < 32'(w_ff)) ? CW'($countones(hit)) : '0;
         end
      end
   end

   // best count, smallest value on ties: pairwise tree over the cells
   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         tc[i] = cnt_ff[i];
         tv[i] = win_ff[i];
      end
      for (int i = MAX_WINDOW; i < NP; i++) begin
         tc[i] = '0;
         tv[i] = '0;
      end
      for (int s = NP >> 1; s >= 1; s = s >> 1) begin
         for (int i = 0; i < s; i++) begin
            if (tc[i+s] > tc[i] || (tc[i+s] == tc[i] && tv[i+s] < tv[i])) begin
               tc[i] = tc[i+s];
               tv[i] = tv[i+s];
            end
         end
      end
      best_v = tv[0];
   end

   // saturating sum
   always_comb begin
      add    = {1'b0, sum_ff} + (SUM_W+1)'(best_v);
      sum_in = sum_ff;
      sat_in = sat_ff;
      if (sat_ff || add[SUM_W]) begin
         sum_in = '1;
         sat_in = 1'b1;
      end else begin
         sum_in = add[SUM_W-1:0];
         if (&add[SUM_W-1:0]) sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         win_ff[0] <= job.sample;
         for (int c = 1; c < MAX_WINDOW; c++) win_ff[c] <= win_ff[c-1];
         w_ff <= CW'(job.win);
      end
      if (st_ff == ST_PICK) begin
         out_ff.mode          <= best_v;
         out_ff.mode_sum      <= sum_in;
         out_ff.sum_saturated <= sat_in;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         ov_ff  <= 1'b0;
         sum_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (take) begin
                  if (job.restart) begin
                     sum_ff <= '0;
                     sat_ff <= 1'b0;
                  end
                  if (job.emit) st_ff <= ST_TALLY;
               end
            end
            ST_TALLY: st_ff <= ST_PICK;
            ST_PICK: begin
               sum_ff <= sum_in;
               sat_ff <= sat_in;
               ov_ff  <= 1'b1;
               st_ff  <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   ast_sat_sticky: assert property (@(posedge clock) disable iff (reset)
      sat_ff && !(take && job.restart) |=> sat_ff) else $error("sat dropped");
   ast_sat_max: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> &sum_ff) else $error("sat without max");
   ast_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_IDLE |-> !take) else $error("take while busy");
   ast_out_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && rsp_stall |=> ov_ff && $stable(out_ff)) else $error("out lost");

endmodule

/* rtl/sliding_window_mode_sum_unit.sv */
// Sliding window mode filter. One sample word enters and, once the window
// holds window_size samples, one result word leaves with the window's mode
// (smallest value on ties) and a saturating running sum of modes. An item
// that yields a result holds the tally engine through its tally and pick
// states before it returns to idle; an item without result is taken in idle.
// A two-entry queue sits between the input stage and the tally engine.
// ----------------------------------------------------------------------------
// sliding_window_mode_sum_unit: top level
// Register port, input stage, job queue and tally engine.
// ----------------------------------------------------------------------------
module sliding_window_mode_sum_unit
   import swms_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [1:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic [WSIZE_W-1:0] wsize_ff;
   logic               jf_valid, jf_stall, jb_valid, jb_stall;
   job_type            jf, jb;

   assign pready = 1'b1;
   assign prdata = (paddr[1:0] == {REG_WINDOW_SIZE, 1'b0}) ? 32'(wsize_ff) : 32'd0;

   // window size register
   always_ff @(posedge clock) begin
      if (reset) wsize_ff <= WSIZE_W'(1);
      else if (psel && penable && pwrite && paddr[1:0] == {REG_WINDOW_SIZE, 1'b0})
         wsize_ff <= pwdata[WSIZE_W-1:0];
   end

   swms_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .win_size(wsize_ff), .job_valid(jf_valid), .job_stall(jf_stall), .job(jf));

   swms_queue u_queue (
      .clock, .reset, .in_valid(jf_valid), .in_stall(jf_stall), .in_job(jf),
      .out_valid(jb_valid), .out_stall(jb_stall), .out_job(jb));

   swms_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
      .clock, .reset, .job_valid(jb_valid), .job_stall(jb_stall), .job(jb),
      .rsp_valid, .rsp_stall, .rsp_word);

endmodule

/* sim/swms_mode_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swms_mode_checker: result predictor and scoreboard for the mode filter
// Watches the register port and both word channels, keeps its own window
// history and running sum, and compares each result word with the oldest
// expected one.
// ----------------------------------------------------------------------------
module swms_mode_checker
   import swms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic         pready,
   input  logic [1:0]   paddr,
   input  logic [31:0]  pwdata,
   output int           fail_count,
   output int           pending_count
);

   localparam int DEPTH = 64;
   localparam logic [SUM_W-1:0] SUM_TOP = {SUM_W{1'b1}};

   // model state
   logic [SAMPLE_W-1:0] history [DEPTH];
   logic [5:0]          wr_ptr;
   logic [6:0]          held;
   logic [SUM_W-1:0]    mode_total;
   logic                total_stuck;
   logic [WSIZE_W-1:0]  win_reg;

   rsp_word_type expected_modes [$];
   int           mismatches = 0;

   assign fail_count    = mismatches;
   assign pending_count = expected_modes.size();

   // mode of the last w samples, smallest value on ties
   function automatic logic [SAMPLE_W-1:0] window_mode(int w);
      logic [SAMPLE_W-1:0] v;
      logic [SAMPLE_W-1:0] best_v;
      logic [5:0]          pos;
      int                  best_c;
      int                  c;
      best_v = '0;
      best_c = 0;
      for (int i = 0; i < w; i++) begin
         pos = wr_ptr - 6'(i + 1);
         v = history[pos];
         c = 0;
         for (int j = 0; j < w; j++) begin
            if (history[wr_ptr - 6'(j + 1)] == v) c++;
         end
         if (c > best_c || (c == best_c && v < best_v)) begin
            best_c = c;
            best_v = v;
         end
      end
      return best_v;
   endfunction

   // advance the model by one accepted sample word
   task automatic take_sample(req_word_type word);
      int                  w;
      logic [SAMPLE_W-1:0] m;
      rsp_word_type        res;
      if (word.restart) begin
         wr_ptr      = '0;
         held        = '0;
         mode_total  = '0;
         total_stuck = 1'b0;
      end
      history[wr_ptr] = word.sample;
      wr_ptr = wr_ptr + 6'd1;
      if (held < DEPTH) held = held + 7'd1;
      w = (win_reg == 0) ? 1 : (win_reg > DEPTH) ? DEPTH : int'(win_reg);
      if (held >= w) begin
         m = window_mode(w);
         if (total_stuck || {{(SUM_W-SAMPLE_W){1'b0}}, m} > SUM_TOP - mode_total) begin
            mode_total  = SUM_TOP;
            total_stuck = 1'b1;
         end else begin
            mode_total = mode_total + SUM_W'(m);
            if (mode_total == SUM_TOP) total_stuck = 1'b1;
         end
         res.mode          = m;
         res.mode_sum      = mode_total;
         res.sum_saturated = total_stuck;
         expected_modes.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         wr_ptr      = '0;
         held        = '0;
         mode_total  = '0;
         total_stuck = 1'b0;
         win_reg     = 7'd1;
         expected_modes.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready && paddr == {1'b0, REG_WINDOW_SIZE})
            win_reg = pwdata[WSIZE_W-1:0];
         // incoming sample words
         if (req_valid && !req_stall) take_sample(req_word);
         // outgoing result words
         if (rsp_valid && !rsp_stall) begin
            if (expected_modes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result word mode=%h sum=%h sat=%b", $realtime,
                           rsp_word.mode, rsp_word.mode_sum, rsp_word.sum_saturated);
            end else begin
               want = expected_modes.pop_front();
               if (want.mode !== rsp_word.mode || want.mode_sum !== rsp_word.mode_sum ||
                   want.sum_saturated !== rsp_word.sum_saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch exp mode=%h sum=%h sat=%b got mode=%h sum=%h sat=%b",
                              $realtime, want.mode, want.mode_sum, want.sum_saturated,
                              rsp_word.mode, rsp_word.mode_sum, rsp_word.sum_saturated);
               end
            end
         end
      end
   end

endmodule

/* sim/tb_sliding_window_mode_sum_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_mode_sum_unit: testbench top for the mode filter
// Drives sample words and window size writes with random gaps and result
// stalls; a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_sliding_window_mode_sum_unit;
   import swms_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [1:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   int fail_count;
   int pending_count;
   int cycles = 0;
   int stall_left = 0;
   bit no_idle = 1'b0;

   always #1 clock = ~clock;

   sliding_window_mode_sum_unit dut (
      .clock, .reset, .req_valid, .req_stall, .req_word, .rsp_valid, .rsp_stall, .rsp_word,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   swms_mode_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_word, .rsp_valid, .rsp_stall, .rsp_word,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending_count
   );

   // run time guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: stall for a random count after each accepted word
   always @(posedge clock) begin
      int n;
      if (reset) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if (rsp_valid && !rsp_stall) begin
         n = no_idle ? 0 : $urandom_range(0, 4);
         stall_left <= n;
         rsp_stall  <= (n != 0);
      end
   end

   // one sample word, with a random gap ahead of it
   task automatic send_sample(logic [SAMPLE_W-1:0] s, logic r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_word.sample  <= s;
      req_word.restart <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // drain, let trailing no-result words retire, then write window size
   task automatic set_window(logic [WSIZE_W-1:0] w);
      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (8) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {1'b0, REG_WINDOW_SIZE};
      pwdata  <= 32'(w);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // random sequences over a small alphabet, with some noise
   task automatic random_phase(logic [WSIZE_W-1:0] w, int items);
      logic [SAMPLE_W-1:0] alphabet [6];
      int                  alpha_n;
      int                  run;
      int                  k;
      k = 0;
      while (k < items) begin
         alpha_n = $urandom_range(1, 6);
         foreach (alphabet[i]) alphabet[i] = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                                      : 16'($urandom_range(0, 15));
         run = $urandom_range(1, 2 * ((w == 0 || w > 64) ? 64 : int'(w)) + 10);
         for (int i = 0; i < run && k < items; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_sample(16'($urandom), $urandom_range(0, 29) == 0);
            else
               send_sample(alphabet[$urandom_range(0, alpha_n - 1)],
                           i == 0 && $urandom_range(0, 7) != 0);
            k++;
         end
      end
   endtask

   initial begin
      logic [WSIZE_W-1:0] sizes [12];
      sizes = '{7'd1, 7'd2, 7'd0, 7'd5, 7'd64, 7'd3, 7'd127, 7'd8, 7'd65, 7'd16, 7'd1, 7'd4};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // window of one, extreme samples
      set_window(7'd1);
      send_sample(16'h0000, 1'b1);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      // window of three, majority picks
      set_window(7'd3);
      send_sample(16'd5, 1'b1);
      send_sample(16'd7, 1'b0);
      send_sample(16'd5, 1'b0);
      send_sample(16'd7, 1'b0);
      send_sample(16'd7, 1'b0);
      send_sample(16'd9, 1'b0);
      // shrink mid-sequence to two: tie goes to smaller value
      set_window(7'd2);
      send_sample(16'd3, 1'b0);
      send_sample(16'd1, 1'b0);
      // size zero acts as one
      set_window(7'd0);
      send_sample(16'd2, 1'b0);
      // grow past what is held: no result until enough samples
      set_window(7'd16);
      send_sample(16'd4, 1'b0);
      send_sample(16'd4, 1'b1);
      send_sample(16'd4, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      // size above the maximum clamps to 64
      set_window(7'd127);
      send_sample(16'hAAAA, 1'b1);
      send_sample(16'h5555, 1'b0);

      // random part
      foreach (sizes[p]) begin
         set_window(p == 10 ? 7'($urandom_range(1, 64)) : sizes[p]);
         no_idle = (p % 4 == 3);
         random_phase(sizes[p], 110);
      end
      no_idle = 1'b0;

      req_valid <= 1'b0;
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
